// ===== rtl/bsr_pkg.sv =====
// ----------------------------------------------------------------------------
// bsr_pkg: shared types and constants of the Babylonian square root core
// Field widths, register indexes, status codes, controller types.
// ----------------------------------------------------------------------------
package bsr_pkg;

    localparam int FRAC_BITS_DEFAULT = 32;

    localparam int RAD_W   = 32;              // radicand / start guess
    localparam int ROOT_W  = 49;              // signed fixed-point guess
    localparam int QUOT_W  = 51;              // quotient incl. cap bit
    localparam int GUESS_W = RAD_W + ROOT_W;  // wide pre-saturation value
    localparam int TOL_W   = 16;
    localparam int ITER_W  = 8;
    localparam int STATUS_W = 2;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_TOLERANCE = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_ITER  = 1'b1;

    localparam logic [TOL_W-1:0]  TOL_RESET      = 16'd0;
    localparam logic [ITER_W-1:0] MAX_ITER_RESET = 8'd64;

    localparam logic [QUOT_W-1:0] QUOT_CAP = 51'h4_0000_0000_0000;  // 2^50

    typedef enum logic [STATUS_W-1:0] {
        ST_CONVERGED    = 2'd0,
        ST_ZERO_GUESS   = 2'd1,
        ST_NEG_RADICAND = 2'd2,
        ST_LIMIT        = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_STEP,
        S_EVAL,
        S_DONE
    } state_t;

    typedef struct packed {
        logic    load;       // capture input item
        logic    div_start;  // launch quotient
        logic    step;       // register next guess
        logic    update;     // commit next guess, count step
        logic    finish;     // latch status code
        status_t code;
        logic    out_load;   // move result to output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic rad_neg;
        logic g_zero;
        logic div_busy;
        logic converged;
        logic at_limit;
        logic out_free;
    } ctrl_sts_t;

endpackage

// ===== rtl/bsr_divider.sv =====
// ----------------------------------------------------------------------------
// bsr_divider: restoring fixed-point divider
// floor(dividend * 2^(2*FRAC_BITS) / divisor), one quotient bit per cycle,
// capped at 2^50.
// ----------------------------------------------------------------------------
module bsr_divider #(
    parameter int FRAC_BITS = bsr_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [bsr_pkg::RAD_W-1:0]    dividend,
    input  logic [bsr_pkg::ROOT_W-1:0]   divisor,
    output logic                         busy,
    output logic [bsr_pkg::QUOT_W-1:0]   quotient
);

    localparam int STEPS = bsr_pkg::RAD_W + 2 * FRAC_BITS;
    localparam int CNT_W = $clog2(STEPS + 1);
    localparam int REM_W = bsr_pkg::ROOT_W;

    logic [CNT_W-1:0]              cnt_reg;
    logic [bsr_pkg::RAD_W-1:0]     v_reg, v_next;
    logic [REM_W-1:0]              d_reg;
    logic [REM_W-1:0]              rem_reg, rem_next;
    logic [bsr_pkg::QUOT_W-1:0]    q_reg, q_next;

    logic [REM_W:0] rem_sh;
    logic [REM_W:0] rem_diff;
    logic           rem_ge;

    always_comb begin
        rem_sh   = {rem_reg, v_reg[bsr_pkg::RAD_W-1]};
        rem_diff = rem_sh - {1'b0, d_reg};
        rem_ge   = rem_sh >= {1'b0, d_reg};
        rem_next = rem_ge ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
        v_next   = {v_reg[bsr_pkg::RAD_W-2:0], 1'b0};
        // quotient freezes once it reaches the cap
        if (q_reg < bsr_pkg::QUOT_CAP) begin
            q_next = {q_reg[bsr_pkg::QUOT_W-2:0], rem_ge};
        end else begin
            q_next = q_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CNT_W'(STEPS);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg   <= dividend;
            d_reg   <= divisor;
            rem_reg <= '0;
            q_reg   <= '0;
        end else if (cnt_reg != '0) begin
            v_reg   <= v_next;
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = (q_reg > bsr_pkg::QUOT_CAP) ? bsr_pkg::QUOT_CAP : q_reg;

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy)
        else $error("divider not busy after start");

endmodule

// ===== rtl/bsr_datapath.sv =====
// ----------------------------------------------------------------------------
// bsr_datapath: guess, step arithmetic, counters and result register
// Holds config, current guess, iteration count, divider and output stage.
// ----------------------------------------------------------------------------
module bsr_datapath #(
    parameter int FRAC_BITS = bsr_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [bsr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [bsr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic signed [bsr_pkg::RAD_W-1:0]  radicand,
    input  logic signed [bsr_pkg::RAD_W-1:0]  start_guess,
    input  bsr_pkg::ctrl_cmd_t                cmd,
    output bsr_pkg::ctrl_sts_t                sts,
    input  logic                              m_ready,
    output logic                              m_valid,
    output logic signed [bsr_pkg::ROOT_W-1:0] root,
    output bsr_pkg::status_t                  status,
    output logic [bsr_pkg::ITER_W-1:0]        iterations
);

    localparam int ROOT_W = bsr_pkg::ROOT_W;
    localparam int GW     = bsr_pkg::GUESS_W;
    localparam int SUM_W  = bsr_pkg::QUOT_W + 2;
    localparam int DIFF_W = ROOT_W + 1;

    // clamp a wide two's complement value to the root range
    function automatic logic [ROOT_W-1:0] sat_root(input logic [GW-1:0] v);
        logic [GW-ROOT_W:0] hi;
        logic [ROOT_W-1:0]  r;
        hi = v[GW-1:ROOT_W-1];
        if ((&hi) || !(|hi)) begin
            r = v[ROOT_W-1:0];
        end else if (v[GW-1]) begin
            r = {1'b1, {(ROOT_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(ROOT_W-1){1'b1}}};
        end
        return r;
    endfunction

    logic [bsr_pkg::TOL_W-1:0]  tol_reg;
    logic [bsr_pkg::ITER_W-1:0] max_it_reg;
    logic [bsr_pkg::RAD_W-1:0]  rad_reg;
    logic [ROOT_W-1:0]          g_reg;
    logic [ROOT_W-1:0]          next_reg, next_next;
    logic [bsr_pkg::ITER_W-1:0] iter_reg, iter_next;
    bsr_pkg::status_t           status_reg;

    logic [ROOT_W-1:0]          root_reg;
    bsr_pkg::status_t           status_out_reg;
    logic [bsr_pkg::ITER_W-1:0] iter_out_reg;
    logic                       m_valid_reg;

    logic [GW-1:0]              guess_wide;
    logic [ROOT_W-1:0]          guess_init;
    logic [ROOT_W-1:0]          divisor;
    logic                       div_busy;
    logic [bsr_pkg::QUOT_W-1:0] quotient;
    logic [SUM_W-1:0]           g_ext, q_ext, sum;
    logic [GW-1:0]              half_wide;
    logic signed [DIFF_W-1:0]   diff, tol_pos, tol_neg;

    // start guess to fixed point, saturated
    always_comb begin
        guess_wide = {{ROOT_W{start_guess[bsr_pkg::RAD_W-1]}}, start_guess} << FRAC_BITS;
        guess_init = sat_root(guess_wide);
    end

    assign divisor = g_reg[ROOT_W-1] ? (ROOT_W'(0) - g_reg) : g_reg;

    bsr_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (rad_reg),
        .divisor  (divisor),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // quotient takes the sign of the guess; halve rounding toward -inf
    always_comb begin
        g_ext = {{(SUM_W-ROOT_W){g_reg[ROOT_W-1]}}, g_reg};
        q_ext = {2'b00, quotient};
        sum   = g_reg[ROOT_W-1] ? (g_ext - q_ext) : (g_ext + q_ext);
        half_wide = {{(GW-SUM_W+1){sum[SUM_W-1]}}, sum[SUM_W-1:1]};
        next_next = sat_root(half_wide);
    end

    always_comb begin
        diff    = $signed({next_reg[ROOT_W-1], next_reg}) - $signed({g_reg[ROOT_W-1], g_reg});
        tol_pos = $signed({{(DIFF_W-bsr_pkg::TOL_W){1'b0}}, tol_reg});
        tol_neg = -tol_pos;
        iter_next = iter_reg + bsr_pkg::ITER_W'(1);
    end

    always_comb begin
        sts.rad_neg   = rad_reg[bsr_pkg::RAD_W-1];
        sts.g_zero    = (g_reg == '0);
        sts.div_busy  = div_busy;
        sts.converged = (diff <= tol_pos) && (diff >= tol_neg);
        sts.at_limit  = (iter_next >= max_it_reg);
        sts.out_free  = !m_valid_reg || m_ready;
    end

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg    <= bsr_pkg::TOL_RESET;
            max_it_reg <= bsr_pkg::MAX_ITER_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                bsr_pkg::REG_TOLERANCE: tol_reg    <= cfg_wdata[bsr_pkg::TOL_W-1:0];
                bsr_pkg::REG_MAX_ITER:  max_it_reg <= cfg_wdata[bsr_pkg::ITER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rad_reg  <= radicand;
            g_reg    <= radicand[bsr_pkg::RAD_W-1] ? '0 : guess_init;
            iter_reg <= '0;
        end else if (cmd.update) begin
            g_reg    <= next_reg;
            iter_reg <= iter_next;
        end
        if (cmd.step) begin
            next_reg <= next_next;
        end
        if (cmd.finish) begin
            status_reg <= cmd.code;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            root_reg       <= g_reg;
            status_out_reg <= status_reg;
            iter_out_reg   <= iter_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign root       = root_reg;
    assign status     = status_out_reg;
    assign iterations = iter_out_reg;

    a_neg_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && status_out_reg == bsr_pkg::ST_NEG_RADICAND)
            |-> (root_reg == '0 && iter_out_reg == '0))
        else $error("negative radicand result not cleared");

    a_conv_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && status_out_reg == bsr_pkg::ST_CONVERGED) |-> (iter_out_reg != '0))
        else $error("converged without a step");

endmodule

// ===== rtl/bsr_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsr_ctrl: iteration sequencer
// Check guess, run divider, form next guess, test convergence and limit.
// ----------------------------------------------------------------------------
module bsr_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bsr_pkg::ctrl_sts_t sts,
    output bsr_pkg::ctrl_cmd_t cmd
);

    bsr_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bsr_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bsr_pkg::S_IDLE: begin
                if (s_valid) state_next = bsr_pkg::S_CHECK;
            end
            bsr_pkg::S_CHECK: begin
                if (sts.rad_neg || sts.g_zero) state_next = bsr_pkg::S_DONE;
                else                           state_next = bsr_pkg::S_DIV;
            end
            bsr_pkg::S_DIV: begin
                if (!sts.div_busy) state_next = bsr_pkg::S_STEP;
            end
            bsr_pkg::S_STEP: begin
                state_next = bsr_pkg::S_EVAL;
            end
            bsr_pkg::S_EVAL: begin
                if (sts.converged || sts.at_limit) state_next = bsr_pkg::S_DONE;
                else                               state_next = bsr_pkg::S_CHECK;
            end
            bsr_pkg::S_DONE: begin
                if (sts.out_free) state_next = bsr_pkg::S_IDLE;
            end
            default: begin
                state_next = bsr_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        cmd.load      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.step      = 1'b0;
        cmd.update    = 1'b0;
        cmd.finish    = 1'b0;
        cmd.code      = bsr_pkg::ST_CONVERGED;
        cmd.out_load  = 1'b0;
        unique case (state_reg)
            bsr_pkg::S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            bsr_pkg::S_CHECK: begin
                if (sts.rad_neg) begin
                    cmd.finish = 1'b1;
                    cmd.code   = bsr_pkg::ST_NEG_RADICAND;
                end else if (sts.g_zero) begin
                    cmd.finish = 1'b1;
                    cmd.code   = bsr_pkg::ST_ZERO_GUESS;
                end else begin
                    cmd.div_start = 1'b1;
                end
            end
            bsr_pkg::S_DIV: begin
            end
            bsr_pkg::S_STEP: begin
                cmd.step = 1'b1;
            end
            bsr_pkg::S_EVAL: begin
                cmd.update = 1'b1;
                // convergence wins over the limit
                if (sts.converged) begin
                    cmd.finish = 1'b1;
                    cmd.code   = bsr_pkg::ST_CONVERGED;
                end else if (sts.at_limit) begin
                    cmd.finish = 1'b1;
                    cmd.code   = bsr_pkg::ST_LIMIT;
                end
            end
            bsr_pkg::S_DONE: begin
                cmd.out_load = sts.out_free;
            end
            default: begin
            end
        endcase
    end

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result register overwritten while pending");

    a_no_div_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> (!sts.g_zero && !sts.rad_neg))
        else $error("division launched on zero guess or negative radicand");

endmodule

// ===== rtl/babylonian_square_root_core.sv =====
// ----------------------------------------------------------------------------
// babylonian_square_root_core: Newton/Babylonian square root, fixed point
// Iterates guess = (radicand/guess + guess)/2 until converged or limited.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel s_*: one item = radicand and start guess (two's
//    complement integers). Taken only while no item is in work.
//  - Result channel m_*: root (signed, FRAC_BITS fraction bits, saturated),
//    status and the number of steps done. One result per input item.
//  - cfg_*: write tolerance (index 0) and max_iterations (index 1) while idle.
//  - Each step runs a guess check, the bit-serial restoring divider, then
//    the next-guess and convergence states.
//  - A negative radicand or a zero guess at entry finishes without a
//    divider run.
//  - Items are worked one at a time; the next item is accepted right after
//    the result enters the output register, even if m_tready is low.
//  - A stalled receiver holds the result in the output register; a
//    finished second item then waits until the first one is taken.
//  - Reset clears the sequencer and output valid, sets tolerance to 0 and
//    max_iterations to 64.
// ----------------------------------------------------------------------------
module babylonian_square_root_core #(
    parameter int FRAC_BITS = bsr_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [31:0] radicand, [63:32] start_guess
    input  logic [63:0]                    s_tdata,
    // result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [48:0] root, [50:49] status, [58:51] iterations, [63:59] zero
    output logic [63:0]                    m_tdata,
    // configuration writes
    input  logic                           cfg_wr_en,
    input  logic [bsr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [bsr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int ROOT_W = bsr_pkg::ROOT_W;
    localparam int PAD_W  = 64 - ROOT_W - bsr_pkg::STATUS_W - bsr_pkg::ITER_W;

    bsr_pkg::ctrl_cmd_t         cmd;
    bsr_pkg::ctrl_sts_t         sts;
    logic signed [ROOT_W-1:0]   root;
    bsr_pkg::status_t           status;
    logic [bsr_pkg::ITER_W-1:0] iterations;

    // sequencer
    bsr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // arithmetic, divider and result register
    bsr_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .radicand    (s_tdata[31:0]),
        .start_guess (s_tdata[63:32]),
        .cmd         (cmd),
        .sts         (sts),
        .m_ready     (m_tready),
        .m_valid     (m_tvalid),
        .root        (root),
        .status      (status),
        .iterations  (iterations)
    );

    assign m_tdata = {{PAD_W{1'b0}}, iterations, status, root};

endmodule

// ===== tb/babylonian_square_root_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// babylonian_square_root_checker: result predictor and scoreboard
// Watches the input, result and register ports of the square root core,
// predicts root, status and step count for every accepted item, and
// compares each result item with the oldest prediction.
// ----------------------------------------------------------------------------
module babylonian_square_root_checker #(
    parameter int FRAC_BITS = bsr_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // [31:0] radicand, [63:32] start_guess
    input  logic [63:0]                    s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // [48:0] root, [50:49] status, [58:51] iterations, [63:59] zero
    input  logic [63:0]                    m_tdata,
    input  logic                           cfg_wr_en,
    input  logic [bsr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [bsr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                             errors,
    output int                             roots_due
);
    import bsr_pkg::*;

    localparam int STATUS_LO = ROOT_W;
    localparam int STEPS_LO  = ROOT_W + STATUS_W;

    typedef struct packed {
        logic [ROOT_W-1:0] root;
        status_t           status;
        logic [ITER_W-1:0] steps;
    } root_result_t;

    root_result_t      expected_roots[$];
    logic [TOL_W-1:0]  tol_reg;
    logic [ITER_W-1:0] iter_limit;

    initial begin
        errors    = 0;
        roots_due = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: checker: %s", $time, msg);
        errors++;
    endtask

    // saturate to the signed root range
    function automatic logic signed [127:0] clamp_root(input logic signed [127:0] v);
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        hi = (128'sd1 <<< (ROOT_W - 1)) - 128'sd1;
        lo = -(128'sd1 <<< (ROOT_W - 1));
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic root_result_t babylon_sqrt(input logic [RAD_W-1:0] rad,
                                                  input logic [RAD_W-1:0] start);
        root_result_t        r;
        logic signed [127:0] guess;
        logic signed [127:0] next;
        logic signed [127:0] delta;
        logic signed [127:0] qs;
        logic [127:0]        mag;
        logic [127:0]        num;
        logic [127:0]        quo;
        int                  steps;
        int                  cap_steps;

        steps     = 0;
        cap_steps = (iter_limit == 0) ? 1 : int'(iter_limit);
        r.root    = '0;
        r.steps   = '0;
        if (rad[RAD_W-1]) begin
            r.status = ST_NEG_RADICAND;
            return r;
        end
        guess = 128'(signed'(start));
        guess = clamp_root(guess <<< FRAC_BITS);
        while (1) begin
            if (guess == 0) begin
                r.status = ST_ZERO_GUESS;
                break;
            end
            mag = (guess < 0) ? -guess : guess;
            num = {96'd0, rad} << (2 * FRAC_BITS);
            quo = num / mag;
            if (quo > 128'(QUOT_CAP)) quo = 128'(QUOT_CAP);
            qs = quo;
            if (guess < 0) qs = -qs;
            // halving floors toward minus infinity
            next = clamp_root((qs + guess) >>> 1);
            steps++;
            delta = next - guess;
            if (delta < 0) delta = -delta;
            guess = next;
            // convergence beats the limit on the same step
            if (delta <= 128'(tol_reg)) begin
                r.status = ST_CONVERGED;
                break;
            end
            if (steps >= cap_steps) begin
                r.status = ST_LIMIT;
                break;
            end
        end
        r.root  = guess[ROOT_W-1:0];
        r.steps = steps[ITER_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        root_result_t want;
        if (!aresetn) begin
            expected_roots.delete();
            tol_reg    = TOL_RESET;
            iter_limit = MAX_ITER_RESET;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_roots.size() == 0) begin
                    report_mismatch($sformatf("unexpected result item %h", m_tdata));
                end else begin
                    want = expected_roots.pop_front();
                    if (m_tdata[ROOT_W-1:0] !== want.root)
                        report_mismatch($sformatf("root %0d, want %0d",
                            $signed(m_tdata[ROOT_W-1:0]), $signed(want.root)));
                    if (m_tdata[STATUS_LO +: STATUS_W] !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                            m_tdata[STATUS_LO +: STATUS_W], want.status));
                    if (m_tdata[STEPS_LO +: ITER_W] !== want.steps)
                        report_mismatch($sformatf("iterations %0d, want %0d",
                            m_tdata[STEPS_LO +: ITER_W], want.steps));
                end
            end
            if (s_tvalid && s_tready)
                expected_roots.push_back(babylon_sqrt(s_tdata[RAD_W-1:0],
                                                      s_tdata[2*RAD_W-1:RAD_W]));
            if (cfg_wr_en) begin
                if (cfg_addr == REG_TOLERANCE) tol_reg = cfg_wdata[TOL_W-1:0];
                else if (cfg_addr == REG_MAX_ITER) iter_limit = cfg_wdata[ITER_W-1:0];
            end
        end
        roots_due <= expected_roots.size();
    end

endmodule

// ===== tb/tb_babylonian_square_root_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_babylonian_square_root_core: stimulus and verdict for the square root core
// Directed corner items under several register settings, then random
// segments of items with random settings and idle patterns, one long
// receiver hold-off; a checker module alongside predicts and compares.
// ----------------------------------------------------------------------------
module tb_babylonian_square_root_core;
    import bsr_pkg::*;

    localparam int    FRAC_BITS      = FRAC_BITS_DEFAULT;
    localparam int    CLK_PERIOD     = 10;
    localparam int    RESET_CYCLES   = 8;
    localparam int    SEGMENTS       = 8;
    localparam int    SEG_ITEMS      = 75;
    localparam int    HOLD_SEGMENT   = 4;
    localparam int    LONG_HOLD      = 3000;    // receiver hold-off, cycles
    localparam int    TAIL_CYCLES    = 300;     // quiet time after the last result
    localparam longint TIMEOUT_CYCLES = 10_000_000;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [63:0]           s_tdata   = '0;   // [31:0] radicand, [63:32] start_guess
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [63:0]           m_tdata;          // [48:0] root, [50:49] status, [58:51] iterations
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int   errors;
    int   roots_due;
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    logic hold_req      = 1'b0;

    always begin
        #(CLK_PERIOD / 2) aclk = 1'b1;
        #(CLK_PERIOD / 2) aclk = 1'b0;
    end

    babylonian_square_root_core #(
        .FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    babylonian_square_root_checker #(
        .FRAC_BITS (FRAC_BITS)
    ) i_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .roots_due (roots_due)
    );

    // Receiver: random stalls at stall_pct; on request one long hold-off,
    // counted here, so the core fills its output register and blocks input.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic set_idling(input idle_mode_t mode);
        send_idle_pct = (mode == IDLE_SENDER)   ? 51 : (mode == IDLE_BOTH) ? 14 : 0;
        stall_pct     = (mode == IDLE_RECEIVER) ? 51 : (mode == IDLE_BOTH) ? 14 : 0;
    endtask

    // Offer one item; returns at the edge where it was taken, valid still high
    // so a back-to-back item needs no second assignment in that step.
    task automatic send_item(input logic [RAD_W-1:0] rad, input logic [RAD_W-1:0] guess);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {guess, rad};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop offering and wait until every predicted result has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (roots_due != 0);
    endtask

    // Both registers, back to back; junk in the unused upper bits of the
    // iteration limit write must be ignored.
    task automatic configure(input logic [TOL_W-1:0] tol, input logic [ITER_W-1:0] limit);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_TOLERANCE;
        cfg_wdata <= tol;
        @(posedge aclk);
        cfg_addr  <= REG_MAX_ITER;
        cfg_wdata <= {(CFG_DATA_W - ITER_W)'($urandom()), limit};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly guesses near the true root (positive or negative), plus zero
    // guesses, tiny guesses, full-range noise and negative radicands.
    task automatic send_random();
        logic [RAD_W-1:0] rad;
        logic [RAD_W-1:0] guess;
        int               near;
        if ($urandom_range(9) == 0)
            rad = $urandom() | 32'h8000_0000;
        else
            rad = ($urandom() & 32'h7FFF_FFFF) >> $urandom_range(30);
        near = $rtoi($sqrt(real'(rad))) + int'($urandom_range(6)) - 3;
        if (near <= 0) near = 1;
        case ($urandom_range(19))
            0, 1:    guess = '0;
            2, 3, 4: guess = $urandom();
            5, 6, 7: begin
                guess = $urandom_range(65536, 1);
                if ($urandom_range(1) == 0) guess = -guess;
            end
            default: begin
                guess = near;
                if ($urandom_range(3) == 0) guess = -guess;
            end
        endcase
        send_item(rad, guess);
    endtask

    initial begin
        logic [TOL_W-1:0]  tol;
        logic [ITER_W-1:0] limit;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: tolerance 0, limit 64
        set_idling(IDLE_NONE);
        send_item(32'd0, 32'd1);              // halves down to a zero guess mid-run
        send_item(32'd16, 32'd4);             // exact root at once
        send_item(32'hFFFF_FFFF, 32'd5);      // negative radicand
        send_item(32'd100, 32'd0);            // zero start guess
        drain();

        // widest tolerance, highest limit
        configure(16'hFFFF, 8'd255);
        send_item(32'h7FFF_FFFF, 32'd1);      // quotient hits its cap
        send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF);  // start guess saturates high
        send_item(32'h7FFF_FFFF, 32'h8000_0000);  // saturates low, negative root
        send_item(32'h8000_0000, 32'd3);      // most negative radicand
        send_item(32'd2, -32'sd2);            // negative guess
        send_item(32'd0, 32'hFFFF_FFFF);
        send_item(32'd1, 32'd1);
        send_item(32'h4000_0000, 32'd32768);
        send_item(32'd12345, 32'd65535);      // largest guess that fits
        send_item(32'd12345, 32'd65536);      // first one that saturates
        send_item(32'd12345, -32'sd65536);    // smallest guess that fits
        send_item(32'd12345, -32'sd65537);
        drain();

        // zero limit behaves as one step
        configure(16'd0, 8'd0);
        send_item(32'd25, 32'd1);
        send_item(32'h7FFF_FFFF, 32'd46341);
        drain();

        // zero tolerance, full limit: may ride out all 255 steps
        configure(16'd0, 8'd255);
        send_item(32'd2, 32'd1);
        send_item(32'd1_000_000, 32'd1000);
        drain();

        // one item converges on the very step that also reaches the limit, one stops at the limit
        configure(16'd1, 8'd1);
        send_item(32'd9, 32'd3);
        send_item(32'd10, 32'd3);
        drain();

        // random segments, each with its own settings and idle pattern
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case ($urandom_range(3))
                0:       tol = '0;
                1:       tol = TOL_W'($urandom_range(64, 1));
                2:       tol = TOL_W'($urandom_range(16'hFFFF));
                default: tol = 16'hFFFF;
            endcase
            case ($urandom_range(3))
                0:       limit = 8'd1;
                1, 2:    limit = ITER_W'($urandom_range(12, 2));
                default: limit = ITER_W'($urandom_range(24, 13));
            endcase
            // short items so two of them fill the core well inside the hold-off
            if (seg == HOLD_SEGMENT) limit = 8'd4;
            configure(tol, limit);
            set_idling(idle_mode_t'(seg % 4));
            if (seg == HOLD_SEGMENT) hold_req = 1'b1;
            repeat (SEG_ITEMS) send_random();
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("tb_babylonian_square_root_core OK");
        else
            $display("tb_babylonian_square_root_core NOT OK");
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("tb_babylonian_square_root_core NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bsr_pkg.sv
rtl/bsr_divider.sv
rtl/bsr_datapath.sv
rtl/bsr_ctrl.sv
rtl/babylonian_square_root_core.sv
tb/babylonian_square_root_checker.sv
tb/tb_babylonian_square_root_core.sv
